// ----- rtl/core/cbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register map and pixel conversion helpers for the clipped blit.
// No dependencies; every other file of the block but cbp_fifo refers to this package by scope.
package cbp_pkg;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned RGB_W      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PAN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_OFFSET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 3'd6;

  typedef enum logic [1:0] {
    FMT_RGB332   = 2'd0,
    FMT_RGB555   = 2'd1,
    FMT_RGB565   = 2'd2,
    FMT_XRGB8888 = 2'd3
  } fmt_t;

  localparam logic [SIZE_W-1:0]     RST_PICTURE_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0]     RST_PICTURE_HEIGHT = 13'd480;
  localparam logic [SIZE_W-1:0]     RST_SCREEN_WIDTH   = 13'd640;
  localparam logic [SIZE_W-1:0]     RST_SCREEN_HEIGHT  = 13'd480;
  localparam logic [CFG_DATA_W-1:0] RST_SOURCE_PAN     = 24'd0;
  localparam logic [CFG_DATA_W-1:0] RST_DEST_OFFSET    = 24'd0;
  localparam fmt_t                  RST_PIXEL_FORMAT   = FMT_RGB565;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  pixel_data;
    logic [2:0]        byte_count;
    logic              last_write;
  } out_t;

  function automatic logic [PIX_W-1:0] convert_pixel(logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b, fmt_t fmt);
    logic [PIX_W-1:0] v;
    case (fmt)
      FMT_RGB332: v = {16'd0, r[7:5], g[7:5], b[7:6]};
      FMT_RGB555: v = {9'd0, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565: v = {8'd0, r[7:3], g[7:2], b[7:3]};
      default:    v = {r, g, b};
    endcase
    return v;
  endfunction

  function automatic logic [2:0] bytes_of(fmt_t fmt);
    logic [2:0] n;
    case (fmt)
      FMT_RGB332:   n = 3'd1;
      FMT_XRGB8888: n = 3'd4;
      default:      n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/cbp_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers and the derived clip geometry (clamped sizes, corrected
// pan and offset, window end). Depends on cbp_pkg.
module cbp_cfg #(
  parameter int unsigned MAX_DIM_BITS = 12,
  localparam int unsigned DW = MAX_DIM_BITS + 1,
  localparam int unsigned CW = ((DW > cbp_pkg::POS_W) ? DW : cbp_pkg::POS_W) + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [DW-1:0]                       pic_w,
  output logic [DW-1:0]                       pic_h,
  output logic [DW-1:0]                       scr_w,
  output logic [CW-1:0]                       pan_x,
  output logic [CW-1:0]                       pan_y,
  output logic [CW-1:0]                       off_x,
  output logic [CW-1:0]                       off_y,
  output logic [CW-1:0]                       end_x,
  output logic [CW-1:0]                       end_y,
  output cbp_pkg::fmt_t                       fmt,
  output logic                                busy
);

  localparam int unsigned EW = (DW > cbp_pkg::SIZE_W) ? DW : cbp_pkg::SIZE_W;
  localparam logic [EW-1:0] DIM_MAX = EW'(1) << MAX_DIM_BITS;
  localparam logic [1:0] SETTLE = 2'd3;
  localparam int unsigned PW = cbp_pkg::POS_W;

  logic [cbp_pkg::SIZE_W-1:0]     pic_w_r, pic_h_r, scr_w_r, scr_h_r;
  logic [cbp_pkg::CFG_DATA_W-1:0] pan_r, off_r;
  cbp_pkg::fmt_t                  fmt_r;
  logic [1:0]                     settle_r;

  logic [DW-1:0] pw_a_r, ph_a_r, sw_a_r, sh_a_r;
  logic [CW-1:0] pan_x_b_r, pan_y_b_r, off_x_b_r, off_y_b_r;
  logic [DW-1:0] win_w_b_r, win_h_b_r;
  logic [CW-1:0] end_x_c_r, end_y_c_r;

  logic [CW-1:0] px_raw, py_raw, ox_raw, oy_raw;

  function automatic logic [DW-1:0] clamp_dim(logic [cbp_pkg::SIZE_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) return DW'(1);
    else if (ve > DIM_MAX) return DW'(DIM_MAX);
    else return DW'(ve);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pic_w_r  <= cbp_pkg::RST_PICTURE_WIDTH;
      pic_h_r  <= cbp_pkg::RST_PICTURE_HEIGHT;
      scr_w_r  <= cbp_pkg::RST_SCREEN_WIDTH;
      scr_h_r  <= cbp_pkg::RST_SCREEN_HEIGHT;
      pan_r    <= cbp_pkg::RST_SOURCE_PAN;
      off_r    <= cbp_pkg::RST_DEST_OFFSET;
      fmt_r    <= cbp_pkg::RST_PIXEL_FORMAT;
      settle_r <= SETTLE;
    end else if (cfg_we) begin
      settle_r <= SETTLE;
      case (cfg_index)
        cbp_pkg::REG_PICTURE_WIDTH:  pic_w_r <= cfg_wdata[cbp_pkg::SIZE_W-1:0];
        cbp_pkg::REG_PICTURE_HEIGHT: pic_h_r <= cfg_wdata[cbp_pkg::SIZE_W-1:0];
        cbp_pkg::REG_SCREEN_WIDTH:   scr_w_r <= cfg_wdata[cbp_pkg::SIZE_W-1:0];
        cbp_pkg::REG_SCREEN_HEIGHT:  scr_h_r <= cfg_wdata[cbp_pkg::SIZE_W-1:0];
        cbp_pkg::REG_SOURCE_PAN:     pan_r   <= cfg_wdata;
        cbp_pkg::REG_DEST_OFFSET:    off_r   <= cfg_wdata;
        cbp_pkg::REG_PIXEL_FORMAT:   fmt_r   <= cbp_pkg::fmt_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign px_raw = CW'(pan_r[PW-1:0]);
  assign py_raw = CW'(pan_r[2*PW-1:PW]);
  assign ox_raw = CW'(off_r[PW-1:0]);
  assign oy_raw = CW'(off_r[2*PW-1:PW]);

  // Geometry pipeline: clamp, then correct pan/offset, then window end.
  always_ff @(posedge clk) begin
    pw_a_r <= clamp_dim(pic_w_r);
    ph_a_r <= clamp_dim(pic_h_r);
    sw_a_r <= clamp_dim(scr_w_r);
    sh_a_r <= clamp_dim(scr_h_r);

    // pan beyond the picture/screen slack falls back to zero
    pan_x_b_r <= (px_raw + CW'(sw_a_r) > CW'(pw_a_r)) ? '0 : px_raw;
    pan_y_b_r <= (py_raw + CW'(sh_a_r) > CW'(ph_a_r)) ? '0 : py_raw;
    // offset that pushes the picture off the screen falls back to zero
    off_x_b_r <= (ox_raw + CW'(pw_a_r) > CW'(sw_a_r)) ? '0 : ox_raw;
    off_y_b_r <= (oy_raw + CW'(ph_a_r) > CW'(sh_a_r)) ? '0 : oy_raw;
    win_w_b_r <= (pw_a_r < sw_a_r) ? pw_a_r : sw_a_r;
    win_h_b_r <= (ph_a_r < sh_a_r) ? ph_a_r : sh_a_r;

    end_x_c_r <= pan_x_b_r + CW'(win_w_b_r);
    end_y_c_r <= pan_y_b_r + CW'(win_h_b_r);
  end

  assign pic_w = pw_a_r;
  assign pic_h = ph_a_r;
  assign scr_w = sw_a_r;
  assign pan_x = pan_x_b_r;
  assign pan_y = pan_y_b_r;
  assign off_x = off_x_b_r;
  assign off_y = off_y_b_r;
  assign end_x = end_x_c_r;
  assign end_y = end_y_c_r;
  assign fmt   = fmt_r;
  assign busy  = (settle_r != '0);

endmodule

// ----- rtl/core/cbp_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks source column/row, clips against the window
// and pushes visible pixels with their screen line and column. Depends on cbp_pkg.
module cbp_front #(
  parameter int unsigned MAX_DIM_BITS = 12,
  localparam int unsigned DW = MAX_DIM_BITS + 1,
  localparam int unsigned CW = ((DW > cbp_pkg::POS_W) ? DW : cbp_pkg::POS_W) + 1,
  localparam int unsigned QW = cbp_pkg::RGB_W + 1 + 2 * CW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbp_pkg::in_t   in_data,
  input  logic [DW-1:0]  pic_w,
  input  logic [DW-1:0]  pic_h,
  input  logic [CW-1:0]  pan_x,
  input  logic [CW-1:0]  pan_y,
  input  logic [CW-1:0]  off_x,
  input  logic [CW-1:0]  off_y,
  input  logic [CW-1:0]  end_x,
  input  logic [CW-1:0]  end_y,
  input  logic           busy,
  input  logic           q_full,
  output logic           push,
  output logic [QW-1:0]  push_data
);

  localparam int unsigned MW = MAX_DIM_BITS;

  logic [MW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [MW-1:0] col_cur, row_cur;
  logic [CW-1:0] colx, rowx, col_inc, row_inc, line, xpos;
  logic          accept, in_win, last;

  assign in_ready = !q_full && !busy;
  assign accept   = in_valid && in_ready;

  assign col_cur = in_data.frame_start ? '0 : col_r;
  assign row_cur = in_data.frame_start ? '0 : row_r;
  assign colx    = CW'(col_cur);
  assign rowx    = CW'(row_cur);
  assign col_inc = colx + CW'(1);
  assign row_inc = rowx + CW'(1);

  assign in_win = (colx >= pan_x) && (colx < end_x) && (rowx >= pan_y) && (rowx < end_y);
  assign last   = (col_inc == end_x) && (row_inc == end_y);
  // only meaningful inside the window, where both stay non-negative
  assign line   = rowx - pan_y + off_y;
  assign xpos   = colx - pan_x + off_x;

  assign push      = accept && in_win;
  assign push_data = {in_data.red, in_data.green, in_data.blue, last, line, xpos};

  always_comb begin
    if (col_inc >= CW'(pic_w)) begin
      col_nxt = '0;
      row_nxt = (row_inc >= CW'(pic_h)) ? '0 : row_inc[MW-1:0];
    end else begin
      col_nxt = col_inc[MW-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/core/cbp_fifo.sv -----
`timescale 1ns / 1ps
// Small register queue between front and back end.
// Standalone; no package use.
module cbp_fifo #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/cbp_back.sv -----
`timescale 1ns / 1ps
// Back end: line times pitch, byte address scaling and format conversion,
// ending in the output register. Depends on cbp_pkg.
module cbp_back #(
  parameter int unsigned MAX_DIM_BITS = 12,
  localparam int unsigned DW = MAX_DIM_BITS + 1,
  localparam int unsigned CW = ((DW > cbp_pkg::POS_W) ? DW : cbp_pkg::POS_W) + 1,
  localparam int unsigned QW = cbp_pkg::RGB_W + 1 + 2 * CW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  logic [QW-1:0]  q_data,
  output logic           q_pop,
  input  logic [DW-1:0]  scr_w,
  input  cbp_pkg::fmt_t  fmt,
  output logic           out_valid,
  input  logic           out_ready,
  output cbp_pkg::out_t  out_data
);

  localparam int unsigned PRW = CW + DW;
  localparam int unsigned PSW = PRW + 1;
  localparam int unsigned AFW = (PSW + 2 > cbp_pkg::ADDR_W) ? PSW + 2 : cbp_pkg::ADDR_W;

  logic                      advance;
  logic [cbp_pkg::RGB_W-1:0] q_rgb;
  logic                      q_last;
  logic [CW-1:0]             q_line, q_xpos;

  logic                      s1_valid_r;
  logic [PRW-1:0]            prod_r;
  logic [CW-1:0]             xpos_r;
  logic [cbp_pkg::RGB_W-1:0] rgb_r;
  logic                      last_r;

  logic [PSW-1:0]            pos;
  logic [AFW-1:0]            pos_ext, addr_full;

  logic                      out_valid_r;
  cbp_pkg::out_t             out_data_r;

  assign q_rgb  = q_data[QW-1 -: cbp_pkg::RGB_W];
  assign q_last = q_data[2*CW];
  assign q_line = q_data[2*CW-1:CW];
  assign q_xpos = q_data[CW-1:0];

  // whole pipe moves unless the output register is full and stalled
  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r <= PRW'(q_line) * PRW'(scr_w);
      xpos_r <= q_xpos;
      rgb_r  <= q_rgb;
      last_r <= q_last;
    end
  end

  always_comb begin
    pos     = PSW'(prod_r) + PSW'(xpos_r);
    pos_ext = AFW'(pos);
    case (fmt)
      cbp_pkg::FMT_RGB332:   addr_full = pos_ext;
      cbp_pkg::FMT_XRGB8888: addr_full = pos_ext << 2;
      default:               addr_full = pos_ext << 1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r.write_address <= addr_full[cbp_pkg::ADDR_W-1:0];
      out_data_r.pixel_data    <= cbp_pkg::convert_pixel(rgb_r[23:16], rgb_r[15:8],
                                                         rgb_r[7:0], fmt);
      out_data_r.byte_count    <= cbp_pkg::bytes_of(fmt);
      out_data_r.last_write    <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/clipped_blit_pixel_format_convert.sv -----
`timescale 1ns / 1ps
// Clipped blit with RGB888 to RGB332/RGB555/RGB565/XRGB8888 conversion.
// Top level; depends on cbp_pkg, cbp_cfg, cbp_front, cbp_fifo and cbp_back.
//
// Usage:
//   in_*   : one RGB888 picture pixel per beat in raster order; frame_start on the
//            first pixel of a picture restarts the column/row counters.
//   out_*  : one framebuffer write per visible pixel (byte address, converted
//            data, byte count, last flag). Clipped pixels produce no beat.
//   cfg_*  : write-only register port, write enable plus index and data.
// Throughput is one pixel per clock while in_ready is high and the receiver keeps
// out_ready high: the front end classifies a pixel combinationally and the back end
// is a two-stage pipe (pitch multiply, then address scale and conversion into the
// output register). A visible pixel passes the queue, the pitch-multiply stage and
// the output register, and waits longer if the queue holds earlier writes.
// After reset and after every register write in_ready stays low while the clip
// geometry pipeline settles; reset also sets the counters to column 0, row 0.
// When the receiver stalls the back end holds its output, the queue of FIFO_DEPTH
// entries fills, and then in_ready drops until the output drains.
module clipped_blit_pixel_format_convert #(
  parameter int unsigned MAX_DIM_BITS = 12,
  parameter int unsigned FIFO_DEPTH   = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cbp_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cbp_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned DW = MAX_DIM_BITS + 1;
  localparam int unsigned CW = ((DW > cbp_pkg::POS_W) ? DW : cbp_pkg::POS_W) + 1;
  localparam int unsigned QW = cbp_pkg::RGB_W + 1 + 2 * CW;

  logic [DW-1:0] pic_w, pic_h, scr_w;
  logic [CW-1:0] pan_x, pan_y, off_x, off_y, end_x, end_y;
  cbp_pkg::fmt_t fmt;
  logic          busy;

  logic          push, q_full, q_pop, q_valid;
  logic [QW-1:0] push_data, q_data;

  cbp_cfg #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pic_w     (pic_w),
    .pic_h     (pic_h),
    .scr_w     (scr_w),
    .pan_x     (pan_x),
    .pan_y     (pan_y),
    .off_x     (off_x),
    .off_y     (off_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .fmt       (fmt),
    .busy      (busy)
  );

  cbp_front #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pic_w     (pic_w),
    .pic_h     (pic_h),
    .pan_x     (pan_x),
    .pan_y     (pan_y),
    .off_x     (off_x),
    .off_y     (off_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .busy      (busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  cbp_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  cbp_back #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .scr_w     (scr_w),
    .fmt       (fmt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
